// ===== sv/srpq_pkg.sv =====
`default_nettype none

package srpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int TAG_W = 16;
	localparam int PRIO_W = 8;
	localparam int ENTRY_W = TAG_W + PRIO_W;
	localparam int STATUS_W = 2;
	localparam int OCC_W = 5;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_POPPED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rd_head;
		logic shift;
		logic place;
		logic pop_take;
		logic res_we;
		logic [STATUS_W-1:0] res_code;
		logic out_load;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic kind;
		logic full;
		logic empty;
		logic left_zero;
		logic left_one;
		logic greater;
	} sts_t;

	function automatic idx_t slot_before(input idx_t s);
		if (s == '0) begin
			slot_before = idx_t'(QUEUE_DEPTH - 1);
		end else begin
			slot_before = s - idx_t'(1);
		end
	endfunction

	function automatic idx_t slot_after(input idx_t s);
		if (s == idx_t'(QUEUE_DEPTH - 1)) begin
			slot_after = '0;
		end else begin
			slot_after = s + idx_t'(1);
		end
	endfunction

endpackage

`default_nettype wire

// ===== sv/srpq_dp.sv =====
`default_nettype none

module srpq_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire srpq_pkg::cmd_t cmd,
	output srpq_pkg::sts_t sts,
	input wire logic kind,
	input wire logic [15:0] tag_in,
	input wire logic [7:0] prio_in,
	output logic [1:0] status,
	output logic [15:0] tag_out,
	output logic [7:0] prio_out,
	output logic [4:0] occupancy
);
	import srpq_pkg::*;

	logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] rdata_q;
	idx_t head_q, tail_q, pos_q, rd_addr, pos_prev;
	cnt_t count_q, left_q;
	logic kind_q;
	logic [TAG_W-1:0] tag_q;
	logic [PRIO_W-1:0] prio_q;
	logic [STATUS_W-1:0] res_code_q;
	logic [TAG_W-1:0] res_tag_q;
	logic [PRIO_W-1:0] res_prio_q;
	logic mem_we;
	idx_t wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	assign pos_prev = slot_before(pos_q);

	// A shift moves pos back by one, so the next read is two slots before it.
	always_comb begin
		if (cmd.rd_head) begin
			rd_addr = head_q;
		end else if (cmd.shift) begin
			rd_addr = slot_before(pos_prev);
		end else begin
			rd_addr = pos_prev;
		end
	end

	assign mem_we = cmd.shift | cmd.place;
	assign wr_addr = pos_q;
	assign wr_data = cmd.shift ? rdata_q : {tag_q, prio_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.place) begin
				tail_q <= slot_after(tail_q);
				count_q <= count_q + cnt_t'(1);
			end else if (cmd.pop_take) begin
				head_q <= slot_after(head_q);
				count_q <= count_q - cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			tag_q <= tag_in;
			prio_q <= prio_in;
			pos_q <= tail_q;
			left_q <= count_q;
		end else if (cmd.shift) begin
			pos_q <= pos_prev;
			left_q <= left_q - cnt_t'(1);
		end
		if (cmd.res_we) begin
			res_code_q <= cmd.res_code;
			res_tag_q <= cmd.pop_take ? rdata_q[ENTRY_W-1:PRIO_W] : '0;
			res_prio_q <= cmd.pop_take ? rdata_q[PRIO_W-1:0] : '0;
		end
		if (cmd.out_load) begin
			status <= res_code_q;
			tag_out <= res_tag_q;
			prio_out <= res_prio_q;
			occupancy <= OCC_W'(count_q);
		end
	end

	assign sts.kind = kind_q;
	assign sts.full = (count_q == cnt_t'(QUEUE_DEPTH));
	assign sts.empty = (count_q == '0);
	assign sts.left_zero = (left_q == '0);
	assign sts.left_one = (left_q == cnt_t'(1));
	assign sts.greater = (rdata_q[PRIO_W-1:0] > prio_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_place_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> !sts.full)
		else $error("entry placed into a full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_take |-> !sts.empty)
		else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== sv/srpq_ctrl.sv =====
`default_nettype none

module srpq_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire srpq_pkg::sts_t sts,
	output srpq_pkg::cmd_t cmd
);
	import srpq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_PLACE = 3'd3;
	localparam logic [2:0] S_POP = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q, state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt = S_LOAD;
				end
			end
			S_LOAD: begin
				if (sts.kind == KIND_INSERT) begin
					if (sts.full) begin
						cmd.res_we = 1'b1;
						cmd.res_code = ST_REJECTED;
						state_nxt = S_DONE;
					end else if (sts.left_zero) begin
						cmd.place = 1'b1;
						cmd.res_we = 1'b1;
						cmd.res_code = ST_INSERTED;
						state_nxt = S_DONE;
					end else begin
						state_nxt = S_SHIFT;
					end
				end else begin
					if (sts.empty) begin
						cmd.res_we = 1'b1;
						cmd.res_code = ST_EMPTY;
						state_nxt = S_DONE;
					end else begin
						cmd.rd_head = 1'b1;
						state_nxt = S_POP;
					end
				end
			end
			S_SHIFT: begin
				if (sts.greater) begin
					cmd.shift = 1'b1;
					if (sts.left_one) begin
						state_nxt = S_PLACE;
					end
				end else begin
					cmd.place = 1'b1;
					cmd.res_we = 1'b1;
					cmd.res_code = ST_INSERTED;
					state_nxt = S_DONE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				cmd.res_we = 1'b1;
				cmd.res_code = ST_INSERTED;
				state_nxt = S_DONE;
			end
			S_POP: begin
				cmd.pop_take = 1'b1;
				cmd.res_we = 1'b1;
				cmd.res_code = ST_POPPED;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_shift_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> !sts.left_zero)
		else $error("shift issued with no entries left to walk");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before it was taken");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_we |=> (state_q == S_DONE))
		else $error("result staged without heading to delivery");

endmodule

`default_nettype wire

// ===== sv/sorted_ring_priority_queue.sv =====
// Channel  Handshake            Beat contents
// -------  -------------------  -------------------------------------------
// input    in_valid / in_ready  kind, tag_in, prio_in
// output   out_valid/out_ready  status, tag_out, prio_out, occupancy
//
// One input beat is processed at a time. From S_LOAD a rejected insert or an
// empty pop goes to S_DONE and a pop through S_POP. An insert into a non-empty
// queue goes through S_SHIFT, which moves each stored entry of larger priority
// one slot later as the single read port walks back from the tail one slot per
// cycle; the entry is then placed. S_DONE loads the result once the output
// register is free. Input is ready again in the cycle after the result loads.
// Reset (arst_n low) empties the queue; the entry memory itself is not cleared.
// A result waits in the output register while the next input beat is taken.
`default_nettype none

module sorted_ring_priority_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic kind,
	input wire logic [15:0] tag_in,
	input wire logic [7:0] prio_in,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] status,
	output logic [15:0] tag_out,
	output logic [7:0] prio_out,
	output logic [4:0] occupancy
);
	import srpq_pkg::*;

	// The controller sequences each beat; the datapath holds the ring of
	// entries, the head, tail and count, and the output register.
	cmd_t cmd;
	sts_t sts;

	srpq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	// An insert walks back from the tail, moving every entry with a strictly
	// larger priority value one slot later, so equal priorities keep their
	// arrival order. A pop always takes the head.
	srpq_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.kind(kind),
		.tag_in(tag_in),
		.prio_in(prio_in),
		.status(status),
		.tag_out(tag_out),
		.prio_out(prio_out),
		.occupancy(occupancy)
	);

endmodule

`default_nettype wire

// ===== test/srpq_checker.sv =====
`default_nettype none

// Watches both channels of the priority queue, keeps its own sorted ring, and
// compares every result beat with the oldest outstanding prediction.
module srpq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic kind,
	input wire logic [srpq_pkg::TAG_W-1:0] tag_in,
	input wire logic [srpq_pkg::PRIO_W-1:0] prio_in,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [srpq_pkg::STATUS_W-1:0] status,
	input wire logic [srpq_pkg::TAG_W-1:0] tag_out,
	input wire logic [srpq_pkg::PRIO_W-1:0] prio_out,
	input wire logic [srpq_pkg::OCC_W-1:0] occupancy,
	output int mismatches,
	output int awaiting,
	output int placed_cnt,
	output int turned_away_cnt,
	output int served_cnt,
	output int dry_pop_cnt
);
	timeunit 1ns;
	timeprecision 1ps;
	import srpq_pkg::*;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [PRIO_W-1:0] prio;
	} ring_entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0] tag;
		logic [PRIO_W-1:0] prio;
		logic [OCC_W-1:0] occ;
	} queue_answer_t;

	ring_entry_t ring [QUEUE_DEPTH];
	int first_slot;
	int free_slot;
	int held;
	int fault_count;
	queue_answer_t predicted_answers [$];

	// Applies one request to the shadow ring and returns the answer it earns.
	// An insert walks back from the free slot, moving strictly larger
	// priorities one slot later, so equal priorities keep arrival order.
	function automatic queue_answer_t serve_request(input logic k,
			input logic [TAG_W-1:0] t, input logic [PRIO_W-1:0] p);
		int pos;
		int left;
		queue_answer_t r;
		r = '0;
		if (k == KIND_INSERT) begin
			if (held >= QUEUE_DEPTH) begin
				r.status = ST_REJECTED;
			end else begin
				pos = free_slot;
				left = held;
				while (left > 0
						&& ring[(pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH].prio > p) begin
					ring[pos] = ring[(pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
					pos = (pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
					left--;
				end
				ring[pos].tag = t;
				ring[pos].prio = p;
				free_slot = (free_slot + 1) % QUEUE_DEPTH;
				held++;
				r.status = ST_INSERTED;
			end
		end else begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.tag = ring[first_slot].tag;
				r.prio = ring[first_slot].prio;
				first_slot = (first_slot + 1) % QUEUE_DEPTH;
				held--;
				r.status = ST_POPPED;
			end
		end
		r.occ = OCC_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_answer_t want;
		if (!arst_n) begin
			first_slot = 0;
			free_slot = 0;
			held = 0;
			fault_count = 0;
			predicted_answers.delete();
			mismatches <= 0;
			awaiting <= 0;
			placed_cnt <= 0;
			turned_away_cnt <= 0;
			served_cnt <= 0;
			dry_pop_cnt <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_answers.push_back(serve_request(kind, tag_in, prio_in));
			end
			if (out_valid && out_ready) begin
				if (predicted_answers.size() == 0) begin
					if (fault_count < 10) begin
						$display("MISMATCH at %0t: result beat with nothing outstanding",
							$time);
					end
					fault_count++;
				end else begin
					want = predicted_answers.pop_front();
					if (status !== want.status || tag_out !== want.tag
							|| prio_out !== want.prio || occupancy !== want.occ) begin
						if (fault_count < 10) begin
							$display({"MISMATCH at %0t: expected status %0d tag %h ",
								"prio %h occ %0d, got status %0d tag %h prio %h occ %0d"},
								$time, want.status, want.tag, want.prio, want.occ,
								status, tag_out, prio_out, occupancy);
						end
						fault_count++;
					end
					case (want.status)
						ST_INSERTED: placed_cnt <= placed_cnt + 1;
						ST_REJECTED: turned_away_cnt <= turned_away_cnt + 1;
						ST_POPPED: served_cnt <= served_cnt + 1;
						default: dry_pop_cnt <= dry_pop_cnt + 1;
					endcase
				end
			end
			mismatches <= fault_count;
			awaiting <= predicted_answers.size();
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_sorted_ring_priority_queue.sv =====
`default_nettype none

// Stimulus and verdict for the sorted ring priority queue. A checker module
// sits beside the block and does all prediction and comparison; this module
// only drives requests, throttles the result channel and decides the outcome.
module tb_sorted_ring_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import srpq_pkg::*;

	// A long hold-off on the result side lets the block fill and stall its
	// input; the watchdog limit must comfortably exceed it.
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	// Worst case insert latency plus margin, used once all results are in.
	localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = KIND_INSERT;
	logic [TAG_W-1:0] tag_in = '0;
	logic [PRIO_W-1:0] prio_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TAG_W-1:0] tag_out;
	logic [PRIO_W-1:0] prio_out;
	logic [OCC_W-1:0] occupancy;

	int mismatches;
	int awaiting;
	int placed_cnt;
	int turned_away_cnt;
	int served_cnt;
	int dry_pop_cnt;

	// Idle mix of the current phase, as a percentage of cycles.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	// The stimulus process asks for a hold-off by bumping holds_asked; the
	// receiver process owns holds_granted, so each variable has one writer.
	int holds_asked = 0;
	int holds_granted = 0;
	int quiet_cycles = 0;

	sorted_ring_priority_queue u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.tag_in(tag_in),
		.prio_in(prio_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.tag_out(tag_out),
		.prio_out(prio_out),
		.occupancy(occupancy)
	);

	srpq_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.tag_in(tag_in),
		.prio_in(prio_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.tag_out(tag_out),
		.prio_out(prio_out),
		.occupancy(occupancy),
		.mismatches(mismatches),
		.awaiting(awaiting),
		.placed_cnt(placed_cnt),
		.turned_away_cnt(turned_away_cnt),
		.served_cnt(served_cnt),
		.dry_pop_cnt(dry_pop_cnt)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Offers one request beat and returns at the edge where it is taken.
	// The caller is always at a rising edge, so when no idle gap is chosen
	// valid simply stays high and the new payload replaces the old one in the
	// same step, with a single nonblocking write per signal.
	task automatic offer_request(input logic k, input logic [TAG_W-1:0] t,
			input logic [PRIO_W-1:0] p);
		int gap;
		gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		tag_in <= t;
		prio_in <= p;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Random request: the insert bias steers the queue toward full or empty.
	// A quarter of the priorities come from a tiny range so that ties are
	// common, and another quarter sit at the two extremes.
	task automatic offer_random(input int insert_bias);
		logic k;
		logic [TAG_W-1:0] t;
		logic [PRIO_W-1:0] p;
		k = ($urandom_range(0, 99) < insert_bias) ? KIND_INSERT : KIND_POP;
		t = TAG_W'($urandom);
		case ($urandom_range(0, 3))
			0: p = PRIO_W'($urandom_range(0, 3));
			1: p = ($urandom_range(0, 1) != 0) ? '1 : '0;
			default: p = PRIO_W'($urandom);
		endcase
		offer_request(k, t, p);
	endtask

	// Result side: random stalls at the phase's rate, or a long hold-off
	// when one has been asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (holds_asked != holds_granted) begin
				holds_granted = holds_asked;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	// Watchdog: any run that goes this long with no beat on either channel
	// is hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int burst;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. A pop on the empty queue comes first, then
		// extreme tags and priorities, including a tie at the top priority
		// value that must come out in arrival order.
		offer_request(KIND_POP, '1, '1);
		offer_request(KIND_INSERT, '1, '1);
		offer_request(KIND_INSERT, '0, '0);
		offer_request(KIND_INSERT, 16'h1234, '1);
		offer_request(KIND_INSERT, 16'h0001, 8'h80);
		offer_request(KIND_POP, '0, '0);
		// Fill to the brim with falling priorities, so every insert has to
		// shift nearly the whole ring, then knock on the full queue.
		for (int i = 0; i < QUEUE_DEPTH - 3; i++) begin
			offer_request(KIND_INSERT, TAG_W'(16'hA000 + i), PRIO_W'(200 - 15 * i));
		end
		offer_request(KIND_INSERT, 16'h5A5A, '0);
		offer_request(KIND_POP, '1, '1);
		offer_request(KIND_POP, '0, '0);

		// Back pressure: the result side holds off while inserts keep coming,
		// so the block must refuse input until the stall lifts.
		holds_asked = holds_asked + 1;
		repeat (12) offer_random(100);

		// Random part in four idle mixes: none, sender idle, receiver
		// stalling, and both. Each phase swings the queue between nearly
		// full and nearly empty so both boundaries get hit repeatedly.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 66;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 66;
				end
				default: begin
					sender_idle_pct = 27;
					receiver_stall_pct = 27;
				end
			endcase
			for (burst = 0; burst < 4; burst++) begin
				repeat (25) offer_random((burst % 2 == 0) ? 80 : 25);
			end
		end
		in_valid <= 1'b0;

		// Let the outstanding count catch up with the final beat, drain all
		// results, then leave room for any stray beat to show up.
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display({"Run covered %0d requests: %0d placed, %0d refused as full, ",
			"%0d served, %0d pops on empty."},
			placed_cnt + turned_away_cnt + served_cnt + dry_pop_cnt,
			placed_cnt, turned_away_cnt, served_cnt, dry_pop_cnt);
		$display({"Idle mixes: none, sender 66%%, receiver 66%%, both 27%%, ",
			"plus a %0d-cycle result hold-off."}, HOLD_CYCLES);
		if (mismatches == 0 && awaiting == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
